// ===== rtl/hdm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hdm_pkg;

  // Stick axis full scale; the divisor is AXIS_FULL_SCALE * (|x| + |y|)
  localparam int AXIS_FULL_SCALE = 127;

  localparam int AXIS_W   = 8;                          // stick and power width
  localparam int MAG_W    = AXIS_W + 1;                 // |x|+|y|, |x+y|, |y-x|
  localparam int SQ_W     = 2 * AXIS_W;                 // x*x + y*y
  localparam int DEN_W    = $clog2(AXIS_FULL_SCALE * (1 << MAG_W) / 2 + 1);
  localparam int Q_W      = AXIS_W - 1;                 // quotient bits below saturation
  localparam int NUM_A_W  = MAG_W + SQ_W;
  localparam int NUM_B_W  = DEN_W + Q_W + 1;
  localparam int NUM_W    = (NUM_A_W > NUM_B_W) ? NUM_A_W : NUM_B_W;
  localparam int DB_W     = 7;

  localparam logic [DB_W-1:0] DEAD_BAND_RESET = DB_W'(15);

  typedef struct packed {
    logic signed [AXIS_W-1:0] stick_x;
    logic signed [AXIS_W-1:0] stick_y;
    logic signed [AXIS_W-1:0] stick_turn;
  } stick_word_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] front_left_power;
    logic signed [AXIS_W-1:0] front_right_power;
    logic signed [AXIS_W-1:0] back_left_power;
    logic signed [AXIS_W-1:0] back_right_power;
    logic                     turning_mode;
  } wheel_word_t;

  // Travels alongside the arithmetic unchanged
  typedef struct packed {
    logic                     turn;
    logic                     neg_l;
    logic                     neg_r;
    logic signed [AXIS_W-1:0] turn_l;
    logic signed [AXIS_W-1:0] turn_r;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [MAG_W-1:0] mag_l;
    logic [MAG_W-1:0] mag_r;
    logic [SQ_W-1:0]  sq;
    logic [DEN_W-1:0] den;
  } prep_t;

  typedef struct packed {
    side_t            side;
    logic [NUM_W-1:0] num_l;
    logic [NUM_W-1:0] num_r;
    logic [DEN_W-1:0] den;
  } num_t;

  typedef struct packed {
    side_t          side;
    logic [Q_W-1:0] q_l;
    logic [Q_W-1:0] q_r;
  } quot_t;

endpackage

`default_nettype wire

// ===== rtl/hdm_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hdm_prep (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [hdm_pkg::DB_W-1:0]  dead_band,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire hdm_pkg::stick_word_t      in_word,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output hdm_pkg::prep_t                 out_word
);
  import hdm_pkg::*;

  // stage A: magnitudes, sums, branch decision
  logic                     a_v;
  logic [AXIS_W-1:0]        a_ax;
  logic [AXIS_W-1:0]        a_ay;
  logic signed [MAG_W-1:0]  a_sum;
  logic signed [MAG_W-1:0]  a_dif;
  logic                     a_turn;
  logic signed [AXIS_W-1:0] a_turn_l;
  logic signed [AXIS_W-1:0] a_turn_r;

  logic                     a_go;
  logic                     b_go;
  logic [AXIS_W-1:0]        ax_c;
  logic [AXIS_W-1:0]        ay_c;
  logic [MAG_W-1:0]         s_c;
  prep_t                    b_next;

  always_comb begin
    ax_c = in_word.stick_x[AXIS_W-1] ? AXIS_W'(-in_word.stick_x) : AXIS_W'(in_word.stick_x);
    ay_c = in_word.stick_y[AXIS_W-1] ? AXIS_W'(-in_word.stick_y) : AXIS_W'(in_word.stick_y);
  end

  assign b_go     = !out_valid || !out_stall;
  assign a_go     = !a_v || b_go;
  assign in_stall = !a_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (a_go) begin
      a_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && in_valid) begin
      a_ax   <= ax_c;
      a_ay   <= ay_c;
      a_sum  <= {in_word.stick_x[AXIS_W-1], in_word.stick_x}
              + {in_word.stick_y[AXIS_W-1], in_word.stick_y};
      a_dif  <= {in_word.stick_y[AXIS_W-1], in_word.stick_y}
              - {in_word.stick_x[AXIS_W-1], in_word.stick_x};
      a_turn <= !((ax_c > {1'b0, dead_band}) || (ay_c > {1'b0, dead_band}));
      // -(-128) clips to +127, and -128 itself clips to -127
      if (in_word.stick_turn == {1'b1, {(AXIS_W-1){1'b0}}}) begin
        a_turn_l <= {1'b0, {(AXIS_W-1){1'b1}}};
        a_turn_r <= {1'b1, {(AXIS_W-2){1'b0}}, 1'b1};
      end else begin
        a_turn_l <= -in_word.stick_turn;
        a_turn_r <= in_word.stick_turn;
      end
    end
  end

  // stage B: squares, divisor, and magnitudes and signs of the sums
  always_comb begin
    s_c                = {1'b0, a_ax} + {1'b0, a_ay};
    b_next.side.turn   = a_turn;
    b_next.side.neg_l  = a_sum[MAG_W-1];
    b_next.side.neg_r  = a_dif[MAG_W-1];
    b_next.side.turn_l = a_turn_l;
    b_next.side.turn_r = a_turn_r;
    b_next.mag_l       = a_sum[MAG_W-1] ? MAG_W'(-a_sum) : MAG_W'(a_sum);
    b_next.mag_r       = a_dif[MAG_W-1] ? MAG_W'(-a_dif) : MAG_W'(a_dif);
    b_next.sq          = SQ_W'(SQ_W'(a_ax) * SQ_W'(a_ax)) + SQ_W'(SQ_W'(a_ay) * SQ_W'(a_ay));
    b_next.den         = DEN_W'(32'(s_c) * AXIS_FULL_SCALE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_go) begin
      out_valid <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && a_v) begin
      out_word <= b_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hdm_numer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hdm_numer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire hdm_pkg::prep_t  in_word,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output hdm_pkg::num_t        out_word
);
  import hdm_pkg::*;

  logic go;

  assign go       = !out_valid || !out_stall;
  assign in_stall = !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= in_valid;
    end
  end

  // |x+y| * m and |y-x| * m, one multiplier per lane
  always_ff @(posedge clk) begin
    if (go && in_valid) begin
      out_word.side  <= in_word.side;
      out_word.num_l <= NUM_W'(in_word.mag_l) * NUM_W'(in_word.sq);
      out_word.num_r <= NUM_W'(in_word.mag_r) * NUM_W'(in_word.sq);
      out_word.den   <= in_word.den;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hdm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hdm_div (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire hdm_pkg::num_t   in_word,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output hdm_pkg::quot_t       out_word
);
  import hdm_pkg::*;

  localparam int NSTG = Q_W + 1;   // saturation check, then one quotient bit a stage

  typedef struct packed {
    side_t            side;
    logic [NUM_W-1:0] rem_l;
    logic [NUM_W-1:0] rem_r;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   q_l;
    logic [Q_W-1:0]   q_r;
  } stage_t;

  logic   v  [NSTG];
  stage_t st [NSTG];
  logic   go [NSTG+1];

  assign go[NSTG] = !out_stall;
  assign in_stall = !go[0];

  for (genvar j = 0; j < NSTG; j++) begin : g_stg
    stage_t nxt;
    logic   v_in;

    assign go[j] = !v[j] || go[j+1];

    if (j == 0) begin : g_sat
      logic [NUM_W-1:0] lim;
      assign v_in = in_valid;
      assign lim  = NUM_W'(in_word.den) << Q_W;
      // quotient of 128 or more clips to all ones; nothing left to divide
      always_comb begin
        nxt.side = in_word.side;
        nxt.den  = in_word.den;
        if (in_word.num_l >= lim) begin
          nxt.q_l   = '1;
          nxt.rem_l = '0;
        end else begin
          nxt.q_l   = '0;
          nxt.rem_l = in_word.num_l;
        end
        if (in_word.num_r >= lim) begin
          nxt.q_r   = '1;
          nxt.rem_r = '0;
        end else begin
          nxt.q_r   = '0;
          nxt.rem_r = in_word.num_r;
        end
      end
    end else begin : g_bit
      localparam int K = Q_W - j;
      logic [NUM_W-1:0] trial;
      assign v_in  = v[j-1];
      assign trial = NUM_W'(st[j-1].den) << K;
      always_comb begin
        nxt = st[j-1];
        if (st[j-1].rem_l >= trial) begin
          nxt.rem_l  = st[j-1].rem_l - trial;
          nxt.q_l[K] = 1'b1;
        end
        if (st[j-1].rem_r >= trial) begin
          nxt.rem_r  = st[j-1].rem_r - trial;
          nxt.q_r[K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (go[j]) begin
        v[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (go[j] && v_in) begin
        st[j] <= nxt;
      end
    end
  end

  assign out_valid     = v[NSTG-1];
  assign out_word.side = st[NSTG-1].side;
  assign out_word.q_l  = st[NSTG-1].q_l;
  assign out_word.q_r  = st[NSTG-1].q_r;

endmodule

`default_nettype wire

// ===== rtl/holonomic_drive_mixer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// X-drive wheel mixer. Each stick word (x, y, turn) gives one wheel word.
// Outside the dead band the stick is mapped circle-to-square:
// left = (x+y)*m/(127*s), right = (y-x)*m/(127*s) with s = |x|+|y| and
// m = x*x+y*y, truncated toward zero and clipped to +/-127; front-left and
// back-right take left, front-right and back-left take right. Inside the
// dead band (both |x| and |y| at or below it) the robot spins: left wheels
// get -turn, right wheels get turn, and turning_mode is set. Throughput is
// one word per clock while wheel_stall is low; the restoring divider
// retires one quotient bit per stage after a saturation check. The
// pipeline only holds while wheel_stall is high, and bubbles close up.
// dead_band resets to 15 and is written with cfg_we; change it only while
// the pipeline is empty.

module holonomic_drive_mixer_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [hdm_pkg::DB_W-1:0]  cfg_data,
  input  wire logic                      stick_valid,
  output logic                           stick_stall,
  input  wire hdm_pkg::stick_word_t      stick,
  output logic                           wheel_valid,
  input  wire logic                      wheel_stall,
  output hdm_pkg::wheel_word_t           wheel
);
  import hdm_pkg::*;

  logic [DB_W-1:0] dead_band;

  logic   prep_valid;
  logic   prep_stall;
  prep_t  prep_word;
  logic   num_valid;
  logic   num_stall;
  num_t   num_word;
  logic   quot_valid;
  logic   quot_stall;
  quot_t  quot_word;

  logic                     out_go;
  logic signed [AXIS_W-1:0] pow_l;
  logic signed [AXIS_W-1:0] pow_r;
  wheel_word_t              wheel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_band <= DEAD_BAND_RESET;
    end else if (cfg_we) begin
      dead_band <= cfg_data;
    end
  end

  // stages A/B: magnitudes, branch, squares, divisor
  hdm_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .dead_band (dead_band),
    .in_valid  (stick_valid),
    .in_stall  (stick_stall),
    .in_word   (stick),
    .out_valid (prep_valid),
    .out_stall (prep_stall),
    .out_word  (prep_word)
  );

  // stage C: numerators
  hdm_numer u_numer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_stall  (prep_stall),
    .in_word   (prep_word),
    .out_valid (num_valid),
    .out_stall (num_stall),
    .out_word  (num_word)
  );

  // eight stages: clip check plus seven quotient bits, both lanes
  hdm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (num_valid),
    .in_stall  (num_stall),
    .in_word   (num_word),
    .out_valid (quot_valid),
    .out_stall (quot_stall),
    .out_word  (quot_word)
  );

  // output register: restore sign, choose branch
  assign out_go     = !wheel_valid || !wheel_stall;
  assign quot_stall = !out_go;

  always_comb begin
    pow_l = quot_word.side.neg_l ? -$signed({1'b0, quot_word.q_l})
                                 :  $signed({1'b0, quot_word.q_l});
    pow_r = quot_word.side.neg_r ? -$signed({1'b0, quot_word.q_r})
                                 :  $signed({1'b0, quot_word.q_r});
    if (quot_word.side.turn) begin
      wheel_next.front_left_power  = quot_word.side.turn_l;
      wheel_next.back_left_power   = quot_word.side.turn_l;
      wheel_next.front_right_power = quot_word.side.turn_r;
      wheel_next.back_right_power  = quot_word.side.turn_r;
      wheel_next.turning_mode      = 1'b1;
    end else begin
      wheel_next.front_left_power  = pow_l;
      wheel_next.back_right_power  = pow_l;
      wheel_next.front_right_power = pow_r;
      wheel_next.back_left_power   = pow_r;
      wheel_next.turning_mode      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_valid <= 1'b0;
    end else if (out_go) begin
      wheel_valid <= quot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_go && quot_valid) begin
      wheel <= wheel_next;
    end
  end

  // spin: each side's pair matches and the sides oppose
  a_spin_pairs: assert property (@(posedge clk) disable iff (rst)
    wheel_valid && wheel.turning_mode |->
      wheel.front_left_power == wheel.back_left_power &&
      wheel.front_right_power == wheel.back_right_power &&
      wheel.front_left_power == -wheel.front_right_power)
    else $error("spin word not symmetric");

  // drive: diagonals match
  a_drive_diag: assert property (@(posedge clk) disable iff (rst)
    wheel_valid && !wheel.turning_mode |->
      wheel.front_left_power == wheel.back_right_power &&
      wheel.front_right_power == wheel.back_left_power)
    else $error("drive diagonals differ");

  // clip keeps every power off the most negative code
  a_clip: assert property (@(posedge clk) disable iff (rst)
    wheel_valid |->
      wheel.front_left_power != 8'sh80 && wheel.front_right_power != 8'sh80 &&
      wheel.back_left_power != 8'sh80 && wheel.back_right_power != 8'sh80)
    else $error("power outside clip range");

  // a word leaving the divider with the output free lands in the output register
  a_handoff: assert property (@(posedge clk) disable iff (rst)
    quot_valid && out_go |=> wheel_valid)
    else $error("divider word lost at output");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import hdm_pkg::*;

  localparam int LATENCY     = 11;      // drain slack after the scoreboard empties
  localparam int CYCLE_LIMIT = 200000;  // far above the slowest correct run
  localparam int MAX_REPORTS = 10;
  localparam int AXIS_SCALE  = 127;
  localparam int POWER_MAX   = 127;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_we = 1'b0;
  logic [DB_W-1:0] cfg_data = '0;
  logic            stick_valid = 1'b0;
  logic            stick_stall;
  stick_word_t     stick = '0;
  logic            wheel_valid;
  logic            wheel_stall = 1'b0;
  wheel_word_t     wheel;

  // Scoreboard state
  wheel_word_t     pending_wheels[$];
  wheel_word_t     want_wheel;
  logic [DB_W-1:0] band_now = DEAD_BAND_RESET;  // mirror of the dead band register
  int              mismatches = 0;
  int unsigned     cycles = 0;
  bit              steady = 1'b0;               // no random idling on either side while set
  int              hold_left = 0;               // receiver hold-off, in cycles

  holonomic_drive_mixer_top u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .stick_valid (stick_valid),
    .stick_stall (stick_stall),
    .stick       (stick),
    .wheel_valid (wheel_valid),
    .wheel_stall (wheel_stall),
    .wheel       (wheel)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Mixer predictor: exact integer maths, division truncates toward zero,
  // every power clipped to +/-127.
  // ---------------------------------------------------------------------------
  function automatic logic signed [7:0] clip_power(int v);
    if (v > POWER_MAX) v = POWER_MAX;
    if (v < -POWER_MAX) v = -POWER_MAX;
    return 8'(v);
  endfunction

  function automatic wheel_word_t mix_wheels(stick_word_t s, logic [DB_W-1:0] band);
    wheel_word_t w;
    int x, y, t, ax, ay, den, sq, lft, rgt;
    x  = $signed(s.stick_x);
    y  = $signed(s.stick_y);
    t  = $signed(s.stick_turn);
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    if (ax > int'(band) || ay > int'(band)) begin
      // translation: circle-to-square onto the two diagonals
      den = AXIS_SCALE * (ax + ay);
      sq  = x * x + y * y;
      lft = 0;
      rgt = 0;
      if (den != 0) begin
        lft = ((x + y) * sq) / den;
        rgt = ((y - x) * sq) / den;
      end
      w.front_left_power  = clip_power(lft);
      w.front_right_power = clip_power(rgt);
      w.back_left_power   = clip_power(rgt);
      w.back_right_power  = clip_power(lft);
      w.turning_mode      = 1'b0;
    end else begin
      // spin on the spot; -(-128) clips to 127
      w.front_left_power  = clip_power(-t);
      w.front_right_power = clip_power(t);
      w.back_left_power   = clip_power(-t);
      w.back_right_power  = clip_power(t);
      w.turning_mode      = 1'b1;
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors, both on the rising edge. Inputs move on the falling edge so
  // there is nothing to race against.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && stick_valid && !stick_stall)
      pending_wheels.push_back(mix_wheels(stick, band_now));
  end

  function automatic void note_fault(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    if (!rst && wheel_valid && !wheel_stall) begin
      if (pending_wheels.size() == 0) begin
        note_fault($sformatf("unexpected wheel word fl=%0d fr=%0d bl=%0d br=%0d turn=%0b",
                             wheel.front_left_power, wheel.front_right_power,
                             wheel.back_left_power, wheel.back_right_power,
                             wheel.turning_mode));
      end else begin
        want_wheel = pending_wheels.pop_front();
        if (wheel.front_left_power  !== want_wheel.front_left_power  ||
            wheel.front_right_power !== want_wheel.front_right_power ||
            wheel.back_left_power   !== want_wheel.back_left_power   ||
            wheel.back_right_power  !== want_wheel.back_right_power  ||
            wheel.turning_mode      !== want_wheel.turning_mode)
          note_fault($sformatf({"wheel mismatch exp fl=%0d fr=%0d bl=%0d br=%0d turn=%0b",
                                " got fl=%0d fr=%0d bl=%0d br=%0d turn=%0b"},
                               want_wheel.front_left_power, want_wheel.front_right_power,
                               want_wheel.back_left_power, want_wheel.back_right_power,
                               want_wheel.turning_mode,
                               wheel.front_left_power, wheel.front_right_power,
                               wheel.back_left_power, wheel.back_right_power,
                               wheel.turning_mode));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: long hold-off when asked, otherwise stalls about a third of
  // the time unless a steady stretch is running.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      wheel_stall = 1'b1;
      hold_left--;
    end else begin
      wheel_stall = !steady && ($urandom_range(0, 99) < 33);
    end
  end

  // ---------------------------------------------------------------------------
  // Driving. Tasks are entered and left at a falling edge; valid is left
  // high after a word so back-to-back words need no toggle.
  // ---------------------------------------------------------------------------
  task automatic send_stick(stick_word_t w);
    while (!steady && $urandom_range(0, 99) < 33) begin
      stick_valid = 1'b0;
      @(negedge clk);
    end
    stick_valid = 1'b1;
    stick       = w;
    @(posedge clk);
    while (stick_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_xyt(int x, int y, int t);
    stick_word_t w;
    w.stick_x    = 8'(x);
    w.stick_y    = 8'(y);
    w.stick_turn = 8'(t);
    send_stick(w);
  endtask

  // Drain the pipe, then write the dead band while nothing is in flight
  task automatic set_dead_band(logic [DB_W-1:0] v);
    stick_valid = 1'b0;
    while (pending_wheels.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we   = 1'b0;
    band_now = v;
  endtask

  // Biased axis value: full range, around the band edge, inside the band,
  // the extremes, and tiny values.
  function automatic int rand_axis(logic [DB_W-1:0] band);
    int sel, v;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: v = int'($urandom_range(0, 255)) - 128;
      4, 5: begin
        v = int'(band) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      6, 7: begin
        v = int'($urandom_range(0, band));
        if ($urandom_range(0, 1)) v = -v;
      end
      8: begin
        case ($urandom_range(0, 5))
          0: v = -128;
          1: v = -127;
          2: v = 127;
          3: v = 1;
          4: v = -1;
          default: v = 0;
        endcase
      end
      default: v = int'($urandom_range(0, 6)) - 3;
    endcase
    return v;
  endfunction

  task automatic send_random_sticks(int count);
    repeat (count)
      send_xyt(rand_axis(band_now), rand_axis(band_now),
               int'($urandom_range(0, 255)) - 128);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset band of 15: both branches, band edges, axis extremes, -128
  task automatic test_reset_band();
    send_xyt(0, 0, 0);
    send_xyt(0, 0, 127);
    send_xyt(0, 0, -128);        // negated turn clips to 127
    send_xyt(15, -15, 64);       // on the edge: still turning
    send_xyt(16, 0, 5);          // just outside on x
    send_xyt(0, -16, 5);         // just outside on y
    send_xyt(127, 127, 0);
    send_xyt(-127, -127, 0);
    send_xyt(127, -127, 0);
    send_xyt(-128, -128, -128);
    send_xyt(-128, 127, 1);
    send_xyt(1, -128, 0);
    send_xyt(100, 37, 0);
    send_xyt(-55, 90, -1);
  endtask

  // Register extremes: zero band and full band
  task automatic test_band_extremes();
    set_dead_band(7'd0);
    send_xyt(0, 0, -127);        // only the centre turns
    send_xyt(1, 0, 0);
    send_xyt(0, -1, 0);
    send_xyt(-1, 1, 99);
    set_dead_band(7'd127);
    send_xyt(127, -127, -128);   // everything in range turns
    send_xyt(-128, 0, 0);        // only -128 gets past the band
    send_xyt(0, -128, 5);
    send_xyt(127, -128, 0);
  endtask

  // Receiver holds off long enough for the pipe to fill and push back
  task automatic test_backpressure();
    set_dead_band(7'd20);
    steady    = 1'b1;
    hold_left = 300;
    send_random_sticks(60);
    steady    = 1'b0;
  endtask

  // Random words over a series of dead band settings; one phase steady
  task automatic test_random_mix();
    logic [DB_W-1:0] bands[6];
    bands = '{7'd15, 7'd0, 7'd127, DB_W'($urandom_range(0, 127)), 7'd1,
              DB_W'($urandom_range(0, 127))};
    foreach (bands[i]) begin
      set_dead_band(bands[i]);
      steady = (i == 2);
      send_random_sticks(230);
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_band();
    test_band_extremes();
    test_backpressure();
    test_random_mix();

    // let the last words out, then a little slack for strays
    stick_valid = 1'b0;
    while (pending_wheels.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
